>>> rtl/tea_block_cipher_assert.svh
// Assertion macros used by the cipher top level.
`ifndef TEA_BLOCK_CIPHER_ASSERT_SVH
`define TEA_BLOCK_CIPHER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TEA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tea_block_cipher: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define TEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tea_block_cipher: next-cycle check failed");

`endif

>>> rtl/tea_pkg.sv
// Types, constants and helpers shared by the TEA cipher pipeline.
`timescale 1ns / 1ps

package tea_pkg;

    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx KEY_IDX0 = 2'd0;
    localparam t_cfg_idx KEY_IDX1 = 2'd1;
    localparam t_cfg_idx KEY_IDX2 = 2'd2;
    localparam t_cfg_idx KEY_IDX3 = 2'd3;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key;

    typedef struct packed {
        logic        kind;
        logic [31:0] left;
        logic [31:0] right;
    } t_block;

    // Running sum after n delta additions, wrapped to 32 bits.
    function automatic logic [31:0] tea_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(n);
        return prod[31:0];
    endfunction

endpackage

>>> rtl/tea_key_regs.sv
// Key register file written through the configuration port.
`timescale 1ns / 1ps

module tea_key_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  tea_pkg::t_cfg_idx i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output tea_pkg::t_key     o_key
);
    import tea_pkg::*;

    t_key r_key;
    t_key n_key;

    always_comb begin
        n_key = r_key;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                KEY_IDX0: n_key.k0 = i_cfg_data;
                KEY_IDX1: n_key.k1 = i_cfg_data;
                KEY_IDX2: n_key.k2 = i_cfg_data;
                KEY_IDX3: n_key.k3 = i_cfg_data;
                default:  n_key = r_key;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

endmodule

>>> rtl/tea_half_round.sv
// One pipeline stage: half of a TEA round (one mix and one add or subtract).
`timescale 1ns / 1ps

module tea_half_round #(
    parameter int ROUNDS    = 32,
    parameter int ROUND_IDX = 0,
    parameter bit SECOND    = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tea_pkg::t_block i_data,
    input  tea_pkg::t_key   i_key,
    output logic            o_valid,
    output tea_pkg::t_block o_data
);
    import tea_pkg::*;

    // Encrypt counts the sum up from delta, decrypt counts down from delta * ROUNDS.
    localparam logic [31:0] SUM_ENC = tea_sum(ROUND_IDX + 1);
    localparam logic [31:0] SUM_DEC = tea_sum(ROUNDS - ROUND_IDX);

    logic        w_enc;
    logic        w_upd_left;
    logic [31:0] w_src;
    logic [31:0] w_old;
    logic [31:0] w_ka;
    logic [31:0] w_kb;
    logic [31:0] w_sum;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    t_block      n_data;
    t_block      r_data;
    logic        r_valid;

    always_comb begin
        w_enc      = (i_data.kind == KIND_ENCRYPT);
        // Encrypt updates left then right; decrypt updates right then left.
        w_upd_left = w_enc ^ SECOND;
        w_src      = w_upd_left ? i_data.right : i_data.left;
        w_old      = w_upd_left ? i_data.left  : i_data.right;
        w_ka       = w_upd_left ? i_key.k0 : i_key.k2;
        w_kb       = w_upd_left ? i_key.k1 : i_key.k3;
        w_sum      = w_enc ? SUM_ENC : SUM_DEC;
        w_mix      = ((w_src << 4) + w_ka) ^ (w_src + w_sum) ^ ((w_src >> 5) + w_kb);
        w_new      = w_enc ? (w_old + w_mix) : (w_old - w_mix);
        n_data     = i_data;
        if (w_upd_left) begin
            n_data.left = w_new;
        end else begin
            n_data.right = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/tea_block_cipher.sv
// Top level: TEA block cipher, fully unrolled into a half-round pipeline.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_kind, i_block_left, i_block_right
//  result    out        o_valid / i_stall   o_out_left, o_out_right
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One block enters per cycle while o_stall is low, with one register stage
// per half round, the last stage being the output register.
// Reset clears the stage valid bits and the four key words.
// A held result under i_stall freezes every stage and raises o_stall; a free
// slot at the output lets the whole pipe advance in the same cycle.
`timescale 1ns / 1ps

module tea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_block_left,
    input  logic [31:0] i_block_right,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_left,
    output logic [31:0] o_out_right,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tea_pkg::*;
    `include "tea_block_cipher_assert.svh"

    localparam int NSTAGE = 2 * ROUNDS;

    t_key             w_key;
    logic             w_en;
    logic [NSTAGE:0]  w_valid;
    t_block           w_data [NSTAGE+1];

    tea_key_regs u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (w_key)
    );

    // Advance everything unless the output holds a result that is not taken.
    assign w_en    = !(w_valid[NSTAGE] && i_stall);
    assign o_stall = !w_en;

    assign w_valid[0]      = i_valid;
    assign w_data[0].kind  = i_kind;
    assign w_data[0].left  = i_block_left;
    assign w_data[0].right = i_block_right;

    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        tea_half_round #(
            .ROUNDS    (ROUNDS),
            .ROUND_IDX (s / 2),
            .SECOND    (1'(s % 2))
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[s]),
            .i_data  (w_data[s]),
            .i_key   (w_key),
            .o_valid (w_valid[s+1]),
            .o_data  (w_data[s+1])
        );
    end

    assign o_valid     = w_valid[NSTAGE];
    assign o_out_left  = w_data[NSTAGE].left;
    assign o_out_right = w_data[NSTAGE].right;

    `TEA_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, w_valid[1])
    `TEA_ASSERT_NEXT(a_freeze_holds_pipe, o_stall, $stable(w_valid[NSTAGE:1]))
    `TEA_ASSERT_NOW(a_stall_needs_result, o_stall, o_valid && i_stall)
    `TEA_ASSERT_NEXT(a_key0_written, i_cfg_we && i_cfg_index == KEY_IDX0, w_key.k0 == $past(i_cfg_data))

endmodule
